// ===== sv/rasg_pkg.sv =====
// Shared types, constants and config helpers for the 3-D ROI align sample generator.
// No dependencies; every other file imports this package.
package rasg_pkg;

  // Fixed-point and field widths
  localparam int FRAC_W     = 8;
  localparam int COORD_W    = 21;
  localparam int EXT_W      = 21;
  localparam int BIN_W      = 4;
  localparam int SUB_W      = 3;
  localparam int GRID_W     = 4;
  localparam int MULT_W     = 8;
  localparam int NUM_W      = EXT_W + MULT_W;
  localparam int DEN_W      = 9;
  localparam int POS_W      = NUM_W + 1;
  localparam int DIM_W      = 9;
  localparam int POOL_W     = 5;
  localparam int RATIO_W    = 4;
  localparam int LOW_W      = 8;
  localparam int FACT_W     = FRAC_W + 1;
  localparam int PAIR_W     = 2 * FACT_W;
  localparam int T_W        = LOW_W + DIM_W;
  localparam int WGT_W      = 25;
  localparam int BASE_W     = 24;
  localparam int CNT_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Limits
  localparam int MAX_DIM    = 256;
  localparam int MAX_POOLED = 16;
  localparam int MAX_GRID   = 8;

  // Pipeline depths: 4 front stages, one per quotient bit, one locate stage
  localparam int AXIS_LAT = 4 + NUM_W + 1;
  localparam int PIPE_LAT = AXIS_LAT + 2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_DEPTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOLED_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POOLED_COLS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POOLED_SLICES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLING_RATIO = 3'd6;

  // Per-axis result handed from the axis pipe to the combine stages
  typedef struct packed {
    logic [LOW_W-1:0]  low;
    logic [FRAC_W-1:0] frac;
    logic              step;
    logic              outside;
    logic [GRID_W-1:0] grid;
    logic              in_grid;
  } axis_res_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

  function automatic logic [POOL_W-1:0] eff_pooled(input logic [POOL_W-1:0] p);
    if (p == '0) return POOL_W'(1);
    if (p > POOL_W'(MAX_POOLED)) return POOL_W'(MAX_POOLED);
    return p;
  endfunction

  function automatic logic [GRID_W-1:0] eff_ratio(input logic [RATIO_W-1:0] r);
    if (r > RATIO_W'(MAX_GRID)) return GRID_W'(MAX_GRID);
    return GRID_W'(r);
  endfunction

endpackage

// ===== sv/roi_align_3d_sample_generator.sv =====
// 3-D ROI align sample generator: one trilinear sample point per input item.
// Pipeline: 4 front stages, 29-stage divider (one quotient bit each), locate, 2 combine.
// Throughput one item per cycle; the whole pipe advances whenever the output is empty or taken.
// Synchronous active-low reset clears valid bits and loads config defaults; no clearing pass.
// Depends on rasg_pkg, rasg_axis and rasg_div.
module roi_align_3d_sample_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rasg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rasg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_h, start_w, start_d, end_h, end_w, end_d,
  // bin_row, bin_col, bin_slice, sub_row, sub_col, sub_slice, zero pad
  input  logic [151:0]                      in_tdata,
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // base_position, neighbor_mask, weight_lll, weight_llh, weight_lhl, weight_lhh,
  // weight_hll, weight_hlh, weight_hhl, weight_hhh, sample_in_grid, sample_count, zero pad
  output logic [239:0]                      out_tdata
);
  import rasg_pkg::*;

  localparam int ONE = 1 << FRAC_W;

  // Config registers
  logic [DIM_W-1:0]   map_height_r, map_width_r, map_depth_r;
  logic [POOL_W-1:0]  pooled_rows_r, pooled_cols_r, pooled_slices_r;
  logic [RATIO_W-1:0] sampling_ratio_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_height_r     <= DIM_W'(1);
      map_width_r      <= DIM_W'(1);
      map_depth_r      <= DIM_W'(1);
      pooled_rows_r    <= POOL_W'(1);
      pooled_cols_r    <= POOL_W'(1);
      pooled_slices_r  <= POOL_W'(1);
      sampling_ratio_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAP_HEIGHT:     map_height_r     <= cfg_data;
        REG_MAP_WIDTH:      map_width_r      <= cfg_data;
        REG_MAP_DEPTH:      map_depth_r      <= cfg_data;
        REG_POOLED_ROWS:    pooled_rows_r    <= cfg_data[POOL_W-1:0];
        REG_POOLED_COLS:    pooled_cols_r    <= cfg_data[POOL_W-1:0];
        REG_POOLED_SLICES:  pooled_slices_r  <= cfg_data[POOL_W-1:0];
        REG_SAMPLING_RATIO: sampling_ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective config values
  logic [DIM_W-1:0]  hd, wd, dd;
  logic [POOL_W-1:0] ph, pw, pd;
  logic [GRID_W-1:0] ratio;

  assign hd    = eff_dim(map_height_r);
  assign wd    = eff_dim(map_width_r);
  assign dd    = eff_dim(map_depth_r);
  assign ph    = eff_pooled(pooled_rows_r);
  assign pw    = eff_pooled(pooled_cols_r);
  assign pd    = eff_pooled(pooled_slices_r);
  assign ratio = eff_ratio(sampling_ratio_r);

  // Pipe advance and valid bits
  logic                en;
  logic [PIPE_LAT-1:0] vld_r;

  assign en         = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  // Per-axis pipes
  axis_res_t ay, ax, az;

  rasg_axis u_axis_y (
    .clk (clk), .en (en),
    .start_i (in_tdata[20:0]),   .end_i (in_tdata[83:63]),
    .bin_i (in_tdata[129:126]),  .sub_i (in_tdata[140:138]),
    .pooled_i (ph), .ratio_i (ratio), .dim_i (hd), .res_o (ay)
  );

  rasg_axis u_axis_x (
    .clk (clk), .en (en),
    .start_i (in_tdata[41:21]),  .end_i (in_tdata[104:84]),
    .bin_i (in_tdata[133:130]),  .sub_i (in_tdata[143:141]),
    .pooled_i (pw), .ratio_i (ratio), .dim_i (wd), .res_o (ax)
  );

  rasg_axis u_axis_z (
    .clk (clk), .en (en),
    .start_i (in_tdata[62:42]),  .end_i (in_tdata[125:105]),
    .bin_i (in_tdata[137:134]),  .sub_i (in_tdata[146:144]),
    .pooled_i (pd), .ratio_i (ratio), .dim_i (dd), .res_o (az)
  );

  // Combine stage 1: partial flat index, y*x weight pairs, sample count
  logic [FACT_W-1:0] fy [2];
  logic [FACT_W-1:0] fx [2];
  logic [T_W-1:0]    t_r;
  logic [PAIR_W-1:0] pair_r [4];
  logic [FACT_W-1:0] fz_r [2];
  logic [LOW_W-1:0]  zl_r;
  logic [2:0]        mask_r;
  logic              outside_r;
  logic              ing_r;
  logic [CNT_W-1:0]  cnt_r;

  assign fy[0] = FACT_W'(ONE) - FACT_W'(ay.frac);
  assign fy[1] = FACT_W'(ay.frac);
  assign fx[0] = FACT_W'(ONE) - FACT_W'(ax.frac);
  assign fx[1] = FACT_W'(ax.frac);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= T_W'(T_W'(ay.low) * T_W'(wd)) + T_W'(ax.low);
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          pair_r[i*2+j] <= PAIR_W'(fy[i]) * PAIR_W'(fx[j]);
        end
      end
      fz_r[0]   <= FACT_W'(ONE) - FACT_W'(az.frac);
      fz_r[1]   <= FACT_W'(az.frac);
      zl_r      <= az.low;
      mask_r    <= {ay.step, ax.step, az.step};
      outside_r <= ay.outside || ax.outside || az.outside;
      ing_r     <= ay.in_grid && ax.in_grid && az.in_grid;
      cnt_r     <= CNT_W'(CNT_W'(ay.grid) * CNT_W'(ax.grid) * CNT_W'(az.grid));
    end
  end

  // Combine stage 2: flat index and the eight weights, zeroed when off the map
  logic [BASE_W-1:0] base_r;
  logic [2:0]        omask_r;
  logic [WGT_W-1:0]  w_r [8];
  logic              oing_r;
  logic [CNT_W-1:0]  ocnt_r;
  logic [T_W+DIM_W-1:0] base_full;

  assign base_full = (T_W+DIM_W)'(t_r) * (T_W+DIM_W)'(dd) + (T_W+DIM_W)'(zl_r);

  always_ff @(posedge clk) begin
    if (en) begin
      base_r  <= outside_r ? '0 : base_full[BASE_W-1:0];
      omask_r <= outside_r ? '0 : mask_r;
      for (int p = 0; p < 4; p++) begin
        for (int k = 0; k < 2; k++) begin
          w_r[p*2+k] <= outside_r ? '0 : WGT_W'(WGT_W'(pair_r[p]) * WGT_W'(fz_r[k]));
        end
      end
      oing_r <= ing_r;
      ocnt_r <= cnt_r;
    end
  end

  assign out_tdata = {2'b00, ocnt_r, oing_r,
                      w_r[7], w_r[6], w_r[5], w_r[4], w_r[3], w_r[2], w_r[1], w_r[0],
                      omask_r, base_r};

endmodule

// ===== sv/rasg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rasg_pkg for widths.
module rasg_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rasg_pkg::NUM_W-1:0] num_i,
  input  logic [rasg_pkg::DEN_W-1:0] den_i,
  output logic [rasg_pkg::NUM_W-1:0] quo_o
);
  import rasg_pkg::*;

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W-1:0] src_rem;
    logic [NUM_W-1:0] src_nq;
    logic [DEN_W-1:0] src_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] nq_nxt;

    if (s == 0) begin : g_first
      assign src_rem = '0;
      assign src_nq  = num_i;
      assign src_den = den_i;
    end else begin : g_rest
      assign src_rem = rem_r[s-1];
      assign src_nq  = nq_r[s-1];
      assign src_den = den_r[s-1];
    end

    // shift in next numerator bit, subtract if it fits
    always_comb begin
      trial = {src_rem, src_nq[NUM_W-1]};
      diff  = trial - {1'b0, src_den};
      if (trial >= {1'b0, src_den}) begin
        rem_nxt = diff[DEN_W-1:0];
        nq_nxt  = {src_nq[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        nq_nxt  = {src_nq[NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nq_r[s]  <= nq_nxt;
        den_r[s] <= src_den;
      end
    end
  end

  assign quo_o = nq_r[NUM_W-1];

endmodule

// ===== sv/rasg_axis.sv =====
// One axis: extent, grid count, sample numerator, divide, then clamp and locate.
// Depends on rasg_pkg and rasg_div.
module rasg_axis (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rasg_pkg::COORD_W-1:0]  start_i,
  input  logic [rasg_pkg::COORD_W-1:0]  end_i,
  input  logic [rasg_pkg::BIN_W-1:0]    bin_i,
  input  logic [rasg_pkg::SUB_W-1:0]    sub_i,
  input  logic [rasg_pkg::POOL_W-1:0]   pooled_i,
  input  logic [rasg_pkg::GRID_W-1:0]   ratio_i,
  input  logic [rasg_pkg::DIM_W-1:0]    dim_i,
  output rasg_pkg::axis_res_t           res_o
);
  import rasg_pkg::*;

  localparam int ONE = 1 << FRAC_W;

  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [GRID_W-1:0]  grid;
    logic               in_grid;
  } side_t;

  // Stage A: extent forced to at least one voxel
  logic signed [COORD_W:0] diff;
  logic [EXT_W-1:0]        ext_nxt;
  logic [COORD_W-1:0]      start_a_r;
  logic [EXT_W-1:0]        ext_a_r;
  logic [BIN_W-1:0]        bin_a_r;
  logic [SUB_W-1:0]        sub_a_r;

  assign diff = $signed({end_i[COORD_W-1], end_i}) - $signed({start_i[COORD_W-1], start_i});
  assign ext_nxt = (diff < $signed((COORD_W+1)'(ONE))) ? EXT_W'(ONE) : diff[EXT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      start_a_r <= start_i;
      ext_a_r   <= ext_nxt;
      bin_a_r   <= bin_i;
      sub_a_r   <= sub_i;
    end
  end

  // Stage B: grid = ratio, or ceil(ext / pooled) saturated at MAX_GRID
  logic [EXT_W-1:0]   thr;
  logic [GRID_W-1:0]  cnt;
  logic [GRID_W-1:0]  grid_nxt;
  logic [COORD_W-1:0] start_b_r;
  logic [EXT_W-1:0]   ext_b_r;
  logic [BIN_W-1:0]   bin_b_r;
  logic [SUB_W-1:0]   sub_b_r;
  logic [GRID_W-1:0]  grid_b_r;

  always_comb begin
    cnt = GRID_W'(1);
    thr = '0;
    for (int k = 1; k < MAX_GRID; k++) begin
      thr = (EXT_W'(k) * EXT_W'(pooled_i)) << FRAC_W;
      if (ext_a_r > thr) cnt = cnt + GRID_W'(1);
    end
    grid_nxt = (ratio_i != '0) ? ratio_i : cnt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start_b_r <= start_a_r;
      ext_b_r   <= ext_a_r;
      bin_b_r   <= bin_a_r;
      sub_b_r   <= sub_a_r;
      grid_b_r  <= grid_nxt;
    end
  end

  // Stage C: multiplier 2*bin*grid + 2*sub + 1 and divisor 2*pooled*grid
  logic [BIN_W+GRID_W-1:0]  bg;
  logic [POOL_W+GRID_W-1:0] pg;
  logic [MULT_W-1:0]        m_nxt;
  logic [DEN_W-1:0]         den_nxt;
  logic [COORD_W-1:0]       start_c_r;
  logic [EXT_W-1:0]         ext_c_r;
  logic [MULT_W-1:0]        m_c_r;
  logic [DEN_W-1:0]         den_c_r;
  logic [GRID_W-1:0]        grid_c_r;
  logic                     ing_c_r;

  assign bg      = (BIN_W+GRID_W)'(bin_b_r) * (BIN_W+GRID_W)'(grid_b_r);
  assign pg      = (POOL_W+GRID_W)'(pooled_i) * (POOL_W+GRID_W)'(grid_b_r);
  assign m_nxt   = {bg[MULT_W-2:0], 1'b0} + MULT_W'({sub_b_r, 1'b0}) + MULT_W'(1);
  assign den_nxt = {pg[DEN_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      start_c_r <= start_b_r;
      ext_c_r   <= ext_b_r;
      m_c_r     <= m_nxt;
      den_c_r   <= den_nxt;
      grid_c_r  <= grid_b_r;
      ing_c_r   <= (GRID_W'(sub_b_r) < grid_b_r);
    end
  end

  // Stage D: numerator product
  logic [NUM_W-1:0] num_d_r;
  logic [DEN_W-1:0] den_d_r;
  side_t            side_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_d_r  <= NUM_W'(ext_c_r) * NUM_W'(m_c_r);
      den_d_r  <= den_c_r;
      side_d_r <= '{start: start_c_r, grid: grid_c_r, in_grid: ing_c_r};
    end
  end

  // Divide, with side data delayed alongside
  logic [NUM_W-1:0] quo;
  side_t            side_r [NUM_W];

  rasg_div u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num_d_r),
    .den_i (den_d_r),
    .quo_o (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_d_r;
      for (int i = 1; i < NUM_W; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Stage E: sample point, range check, clamp and split
  side_t              sd;
  logic signed [POS_W-1:0] pos;
  logic [POS_W-1:0]   posc;
  logic [POS_W-1:0]   lowfull;
  logic [DIM_W-1:0]   dim_m1;
  axis_res_t          res_nxt;

  always_comb begin
    sd      = side_r[NUM_W-1];
    pos     = $signed({{(POS_W-COORD_W){sd.start[COORD_W-1]}}, sd.start})
              + $signed({1'b0, quo});
    posc    = (pos < 0) ? '0 : pos;
    lowfull = posc >> FRAC_W;
    dim_m1  = dim_i - DIM_W'(1);
    res_nxt.grid    = sd.grid;
    res_nxt.in_grid = sd.in_grid;
    res_nxt.outside = (pos < -$signed(POS_W'(ONE)))
                   || (pos > $signed(POS_W'({dim_i, {FRAC_W{1'b0}}})));
    if (lowfull >= POS_W'(dim_m1)) begin
      res_nxt.low  = dim_m1[LOW_W-1:0];
      res_nxt.frac = '0;
      res_nxt.step = 1'b0;
    end else begin
      res_nxt.low  = lowfull[LOW_W-1:0];
      res_nxt.frac = posc[FRAC_W-1:0];
      res_nxt.step = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_o <= res_nxt;
  end

endmodule
